// File: rtl/mrbrm_pkg.sv
// Package with the request and status codes and the field widths of the ring index manager.
package mrbrm_pkg;

    localparam int unsigned CFG_W       = 5;
    localparam int unsigned ID_W        = 4;
    localparam int unsigned BUF_IDX_W   = 4;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned S_TUSER_W   = 2;
    localparam int unsigned M_TDATA_W   = 16;

    typedef enum logic [1:0] {
        REQ_WRITE    = 2'd0,
        REQ_READ     = 2'd1,
        REQ_REGISTER = 2'd2,
        REQ_REMOVE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CAUGHT_UP = 2'd1,
        ST_NO_SLOT   = 2'd2,
        ST_UNKNOWN   = 2'd3
    } t_status;

endpackage

// File: rtl/multi_reader_buffer_ring_manager.sv
// Index manager for a ring of buffers with one writer and several readers.
//
// The block accepts one request transaction per cycle while the output side is ready, and
// returns exactly one result transaction for each. A request is captured in an input
// register together with the stored read index of the named reader, all index updates are
// made in one pass of logic from that register, and the result lands
// in an output register, so a stalled output holds one result while the next request waits
// in the input register. The read indices of the registered readers live in a small memory
// with one write and one registered read per cycle; a write made in the same cycle is
// forwarded to the read. Writing the ring size reinitializes the write and built-in reader
// indices and frees every reader slot; the built-in reader in slot 0 is always present.
module multi_reader_buffer_ring_manager #(
    parameter int unsigned MAX_BUFFERS = 16,
    parameter int unsigned MAX_READERS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_we,
    input  logic [mrbrm_pkg::CFG_W-1:0]         i_cfg_wdata,

    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0: reader_id[3:0], zero padding[7:4].
    input  logic [mrbrm_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // Fields from bit 0: req_type[1:0].
    input  logic [mrbrm_pkg::S_TUSER_W-1:0]     i_s_axis_tuser,

    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // Fields from bit 0: buffer_index[3:0], new_reader_slot[7:4], status[9:8], zero[15:10].
    output logic [mrbrm_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int unsigned PW = $clog2(MAX_BUFFERS);
    localparam int unsigned NW = $clog2(MAX_BUFFERS + 1);
    localparam int unsigned AW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int unsigned EW = (AW > mrbrm_pkg::ID_W) ? AW : mrbrm_pkg::ID_W;
    localparam int unsigned NUM_RESET = (MAX_BUFFERS < 16) ? MAX_BUFFERS : 16;

    function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p, input logic [NW-1:0] num);
        logic [NW:0] s;
        s = (NW+1)'(p) + 1'b1;
        return (s >= (NW+1)'(num)) ? '0 : PW'(s);
    endfunction

    function automatic logic [PW-1:0] pos_before(input logic [PW-1:0] p,
                                                 input logic [NW-1:0] num);
        logic [NW-1:0] m;
        m = num - 1'b1;
        return (p == '0) ? PW'(m) : p - 1'b1;
    endfunction

    logic [NW-1:0]              r_num;
    logic [PW-1:0]              r_wr_pos, n_wr_pos;
    logic [PW-1:0]              r_pos0, n_pos0;
    logic [MAX_READERS-1:0]     r_active, n_active;
    logic [PW-1:0]              r_mem [MAX_READERS];

    logic                       r_in_valid;
    mrbrm_pkg::t_req            r_req;
    logic [mrbrm_pkg::ID_W-1:0] r_id;
    logic [PW-1:0]              r_rd_pos;

    logic                       r_out_valid;
    logic [mrbrm_pkg::M_TDATA_W-1:0] r_out_data;

    logic                       w_adv, w_in_acc;
    logic [NW-1:0]              w_cfg_num;
    logic [EW-1:0]              w_id_m1, w_in_id_m1;
    logic [AW-1:0]              w_id_idx, w_in_idx;
    logic                       w_present;
    logic [PW-1:0]              w_pos_cur, w_wr_before;
    logic                       w_found;
    logic [AW-1:0]              w_free_idx;
    logic                       w_mem_we;
    logic [AW-1:0]              w_mem_addr;
    logic [PW-1:0]              w_mem_wdata;
    logic [mrbrm_pkg::BUF_IDX_W-1:0] w_buf;
    logic [mrbrm_pkg::SLOT_W-1:0]    w_slot;
    mrbrm_pkg::t_status         w_status;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        if (i_cfg_wdata < mrbrm_pkg::CFG_W'(2)) begin
            w_cfg_num = NW'(2);
        end else if (int'(i_cfg_wdata) > MAX_BUFFERS) begin
            w_cfg_num = NW'(MAX_BUFFERS);
        end else begin
            w_cfg_num = NW'(i_cfg_wdata);
        end
    end

    assign w_id_m1    = EW'(r_id) - 1'b1;
    assign w_id_idx   = w_id_m1[AW-1:0];
    assign w_in_id_m1 = EW'(i_s_axis_tdata[mrbrm_pkg::ID_W-1:0]) - 1'b1;
    assign w_in_idx   = w_in_id_m1[AW-1:0];

    assign w_present   = (r_id == '0) || ((int'(r_id) <= MAX_READERS) && r_active[w_id_idx]);
    assign w_pos_cur   = (r_id == '0) ? r_pos0 : r_rd_pos;
    assign w_wr_before = pos_before(r_wr_pos, r_num);

    always_comb begin
        w_found    = 1'b0;
        w_free_idx = '0;
        for (int i = MAX_READERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_found    = 1'b1;
                w_free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        n_wr_pos    = r_wr_pos;
        n_pos0      = r_pos0;
        n_active    = r_active;
        w_mem_we    = 1'b0;
        w_mem_addr  = w_id_idx;
        w_mem_wdata = pos_next(w_pos_cur, r_num);
        w_buf       = '0;
        w_slot      = '0;
        w_status    = mrbrm_pkg::ST_OK;
        unique case (r_req)
            mrbrm_pkg::REQ_WRITE: begin
                w_buf    = mrbrm_pkg::BUF_IDX_W'(r_wr_pos);
                n_wr_pos = pos_next(r_wr_pos, r_num);
            end
            mrbrm_pkg::REQ_READ: begin
                if (!w_present) begin
                    w_status = mrbrm_pkg::ST_UNKNOWN;
                end else if (w_pos_cur == w_wr_before) begin
                    w_status = mrbrm_pkg::ST_CAUGHT_UP;
                end else begin
                    w_buf = mrbrm_pkg::BUF_IDX_W'(w_pos_cur);
                    if (r_id == '0) begin
                        n_pos0 = pos_next(w_pos_cur, r_num);
                    end else begin
                        w_mem_we = 1'b1;
                    end
                end
            end
            mrbrm_pkg::REQ_REGISTER: begin
                if (w_found) begin
                    n_active[w_free_idx] = 1'b1;
                    w_mem_we    = 1'b1;
                    w_mem_addr  = w_free_idx;
                    w_mem_wdata = w_wr_before;
                    w_slot      = mrbrm_pkg::SLOT_W'({1'b0, w_free_idx} + 1'b1);
                end else begin
                    w_status = mrbrm_pkg::ST_NO_SLOT;
                end
            end
            mrbrm_pkg::REQ_REMOVE: begin
                if ((r_id == '0) || !w_present) begin
                    w_status = mrbrm_pkg::ST_UNKNOWN;
                end else begin
                    n_active[w_id_idx] = 1'b0;
                end
            end
            default: begin
                w_status = mrbrm_pkg::ST_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num       <= NW'(NUM_RESET);
            r_wr_pos    <= '0;
            r_pos0      <= PW'(NUM_RESET - 1);
            r_active    <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num    <= w_cfg_num;
                r_wr_pos <= '0;
                r_pos0   <= pos_before('0, w_cfg_num);
                r_active <= '0;
            end else if (w_adv) begin
                r_wr_pos <= n_wr_pos;
                r_pos0   <= n_pos0;
                r_active <= n_active;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_in_acc) begin
            r_req    <= mrbrm_pkg::t_req'(i_s_axis_tuser);
            r_id     <= i_s_axis_tdata[mrbrm_pkg::ID_W-1:0];
            r_rd_pos <= (w_adv && w_mem_we && (w_mem_addr == w_in_idx)) ? w_mem_wdata
                                                                         : r_mem[w_in_idx];
        end
        if (w_adv) begin
            r_out_data <= {(mrbrm_pkg::M_TDATA_W - 10)'(0), w_status, w_slot, w_buf};
        end
    end

    a_wr_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_wr_pos) < r_num)
        else $error("write index outside the ring");

    a_pos0_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_pos0) < r_num)
        else $error("built-in reader index outside the ring");

    a_unknown_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !i_cfg_we && (w_status == mrbrm_pkg::ST_UNKNOWN)
        |=> $stable(r_active) && $stable(r_wr_pos) && $stable(r_pos0))
        else $error("rejected request changed state");

    a_write_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !i_cfg_we && (r_req == mrbrm_pkg::REQ_WRITE)
        |=> r_wr_pos != $past(r_wr_pos))
        else $error("write transaction did not advance the write index");

endmodule

// File: dv/tb_multi_reader_buffer_ring_manager.sv
// Self-checking testbench for the multi-reader buffer ring index manager.
`timescale 1ns / 1ps

module tb_multi_reader_buffer_ring_manager;

    localparam int N_BUFFERS = 16;
    localparam int N_READERS = 8;

    typedef struct {
        mrbrm_pkg::t_req req;
        logic [3:0]      id;
    } t_ring_request;

    typedef struct packed {
        logic [3:0]         buf_idx;
        logic [3:0]         slot;
        mrbrm_pkg::t_status status;
    } t_ring_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [mrbrm_pkg::CFG_W-1:0]        i_cfg_wdata = '0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    // Fields from bit 0: reader_id[3:0], zero padding[7:4].
    logic [mrbrm_pkg::S_TDATA_W-1:0]    i_s_axis_tdata = '0;
    // Fields from bit 0: req_type[1:0].
    logic [mrbrm_pkg::S_TUSER_W-1:0]    i_s_axis_tuser = '0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    // Fields from bit 0: buffer_index[3:0], new_reader_slot[7:4], status[9:8], zero[15:10].
    logic [mrbrm_pkg::M_TDATA_W-1:0]    o_m_axis_tdata;

    t_ring_request request_q[$];
    t_ring_result  expected_results[$];
    int            mismatch_count = 0;
    int            send_idle_pct = 17;
    int            recv_idle_pct = 72;
    int            hold_left = 0;
    logic          hold_req = 1'b0;

    int unsigned   ring_size;
    logic [3:0]    wr_ptr;
    logic [3:0]    rd_ptr [0:N_READERS];
    bit            slot_busy [1:N_READERS];

    multi_reader_buffer_ring_manager u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [3:0] ring_next(logic [3:0] p);
        return (int'(p) + 1 >= ring_size) ? 4'd0 : p + 4'd1;
    endfunction

    function automatic logic [3:0] ring_prev(logic [3:0] p);
        return (p == 4'd0) ? 4'(ring_size - 1) : p - 4'd1;
    endfunction

    function automatic bit reader_present(logic [3:0] id);
        if (id == 4'd0)
            return 1'b1;
        if (int'(id) > N_READERS)
            return 1'b0;
        return slot_busy[id];
    endfunction

    function automatic void apply_ring_size(int value);
        int v;
        v = value & 31;
        if (v < 2)
            v = 2;
        if (v > N_BUFFERS)
            v = N_BUFFERS;
        ring_size = v;
        wr_ptr = 4'd0;
        for (int i = 0; i <= N_READERS; i++)
            rd_ptr[i] = 4'd0;
        for (int i = 1; i <= N_READERS; i++)
            slot_busy[i] = 1'b0;
        rd_ptr[0] = ring_prev(4'd0);
    endfunction

    function automatic t_ring_result ring_predict(mrbrm_pkg::t_req req, logic [3:0] id);
        t_ring_result res;
        bit           found;
        res = '0;
        res.status = mrbrm_pkg::ST_OK;
        found = 1'b0;
        case (req)
            mrbrm_pkg::REQ_WRITE: begin
                res.buf_idx = wr_ptr;
                wr_ptr = ring_next(wr_ptr);
            end
            mrbrm_pkg::REQ_READ: begin
                if (!reader_present(id)) begin
                    res.status = mrbrm_pkg::ST_UNKNOWN;
                end else if (rd_ptr[id] == ring_prev(wr_ptr)) begin
                    res.status = mrbrm_pkg::ST_CAUGHT_UP;
                end else begin
                    res.buf_idx = rd_ptr[id];
                    rd_ptr[id] = ring_next(rd_ptr[id]);
                end
            end
            mrbrm_pkg::REQ_REGISTER: begin
                res.status = mrbrm_pkg::ST_NO_SLOT;
                for (int s = 1; s <= N_READERS; s++) begin
                    if (!found && !slot_busy[s]) begin
                        found = 1'b1;
                        slot_busy[s] = 1'b1;
                        rd_ptr[s] = ring_prev(wr_ptr);
                        res.slot = 4'(s);
                        res.status = mrbrm_pkg::ST_OK;
                    end
                end
            end
            default: begin
                if (id == 4'd0 || !reader_present(id))
                    res.status = mrbrm_pkg::ST_UNKNOWN;
                else
                    slot_busy[id] = 1'b0;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic queue_request(mrbrm_pkg::t_req req, int id);
        t_ring_request entry;
        entry.req = req;
        entry.id = 4'(id);
        request_q = {request_q, entry};
    endtask

    task automatic queue_random_request();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            queue_request(mrbrm_pkg::REQ_WRITE, $urandom_range(N_READERS));
        else if (r < 70)
            queue_request(mrbrm_pkg::REQ_READ, $urandom_range(N_READERS));
        else if (r < 85)
            queue_request(mrbrm_pkg::REQ_REGISTER, $urandom_range(N_READERS));
        else
            queue_request(mrbrm_pkg::REQ_REMOVE, $urandom_range(N_READERS));
    endtask

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (request_q.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_ring_size(int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mrbrm_pkg::CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_ring_size(value);
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_ring_request item;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_results = {expected_results,
                                    ring_predict(mrbrm_pkg::t_req'(i_s_axis_tuser),
                                                 i_s_axis_tdata[3:0])};
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = request_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {4'd0, item.id};
                    i_s_axis_tuser <= item.req;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= 80;
    end

    always @(posedge i_clk) begin : check_results
        t_ring_result want;
        i_m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request pending", int'(o_m_axis_tdata), 0);
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tdata[3:0] != want.buf_idx)
                    report_mismatch("buffer_index", int'(o_m_axis_tdata[3:0]),
                                    int'(want.buf_idx));
                if (o_m_axis_tdata[7:4] != want.slot)
                    report_mismatch("new_reader_slot", int'(o_m_axis_tdata[7:4]),
                                    int'(want.slot));
                if (o_m_axis_tdata[9:8] != want.status)
                    report_mismatch("status", int'(o_m_axis_tdata[9:8]), int'(want.status));
            end
        end
    end

    initial begin : stimulus
        int cfg_plan [9];
        cfg_plan = '{2, 16, 0, 31, $urandom_range(3, 15), 1, $urandom_range(3, 15), 16, 2};
        apply_ring_size(N_BUFFERS);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset ring of 16: catch-up of the built-in reader, full slot table, bad removes.
        queue_request(mrbrm_pkg::REQ_READ, 0);
        queue_request(mrbrm_pkg::REQ_WRITE, 0);
        queue_request(mrbrm_pkg::REQ_WRITE, 0);
        queue_request(mrbrm_pkg::REQ_READ, 0);
        queue_request(mrbrm_pkg::REQ_READ, 0);
        queue_request(mrbrm_pkg::REQ_READ, 0);
        for (int i = 0; i <= N_READERS; i++)
            queue_request(mrbrm_pkg::REQ_REGISTER, 0);
        queue_request(mrbrm_pkg::REQ_READ, 8);
        queue_request(mrbrm_pkg::REQ_WRITE, 0);
        queue_request(mrbrm_pkg::REQ_READ, 8);
        queue_request(mrbrm_pkg::REQ_REMOVE, 0);
        queue_request(mrbrm_pkg::REQ_REMOVE, 3);
        queue_request(mrbrm_pkg::REQ_REMOVE, 3);
        queue_request(mrbrm_pkg::REQ_READ, 3);
        queue_request(mrbrm_pkg::REQ_READ, 12);
        queue_request(mrbrm_pkg::REQ_REMOVE, 15);
        queue_request(mrbrm_pkg::REQ_REMOVE, 9);
        queue_request(mrbrm_pkg::REQ_REGISTER, 0);
        wait_drained();

        for (int phase = 0; phase < 9; phase++) begin
            if (phase < 3) begin
                send_idle_pct = 17;
                recv_idle_pct = 72;
            end else if (phase < 6) begin
                send_idle_pct = 72;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_ring_size(cfg_plan[phase]);
            for (int chunk = 0; chunk < 4; chunk++) begin
                for (int n = 0; n < 35; n++)
                    queue_random_request();
                if (phase == 6 && chunk == 0) begin
                    hold_req <= 1'b1;
                    do
                        @(posedge i_clk);
                    while (hold_left == 0);
                    hold_req <= 1'b0;
                end
                wait_drained();
            end
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/mrbrm_pkg.sv
rtl/multi_reader_buffer_ring_manager.sv
dv/tb_multi_reader_buffer_ring_manager.sv
